// ----- hw/rtl/dcdc_pkg.sv -----
package dcdc_pkg;

   // Row fields as they arrive on the request channel
   localparam int ROW_IN_W = 16;

   // Default capacity: equations (rows) per set
   localparam int MAX_EQUATIONS_DEFAULT = 16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_en;     // store (or drop) the request row
      logic rotate_en;   // one Warshall step, rotate the row ring
      logic compare_en;  // capture per-row full-coverage flags
      logic commit_en;   // write the result register, clear set state
   } dcdc_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic rsp_busy;    // result register holds a transaction not taken this cycle
   } dcdc_status_type;

endpackage

// ----- hw/rtl/dcdc_req_if.sv -----
interface dcdc_req_if
   import dcdc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ROW_IN_W-1:0] uses_x_row;
   logic [ROW_IN_W-1:0] uses_y_row;
   logic                last_row;

   modport source (output valid, output uses_x_row, output uses_y_row, output last_row,
                   input ready);
   modport sink   (input valid, input uses_x_row, input uses_y_row, input last_row,
                   output ready);
endinterface

// ----- hw/rtl/dcdc_rsp_if.sv -----
interface dcdc_rsp_if;
   logic valid;
   logic ready;
   logic decomposable;
   logic overflow;

   modport source (output valid, output decomposable, output overflow, input ready);
   modport sink   (input valid, input decomposable, input overflow, output ready);
endinterface

// ----- hw/rtl/dependency_closure_decompose_check_top.sv -----
// Sequence: after a last-row transaction is accepted, the result appears on rsp after one full
//   lap of the row ring, one compare and one commit; the commit waits while a result is not taken.
// Throughput: one row per cycle while loading; after a last row, no new rows are taken until the
//   set is committed, while the Warshall ring advances one pivot row per cycle.
// Reset: synchronous, active high; clears the row count, overflow flag, result valid and
//   controller state. The row storage is not cleared.
module dependency_closure_decompose_check_top
   import dcdc_pkg::*;
#(
   parameter int MAX_EQUATIONS = MAX_EQUATIONS_DEFAULT,
   localparam int IdxW = (MAX_EQUATIONS > 1) ? $clog2(MAX_EQUATIONS) : 1
) (
   input logic        clock,
   input logic        reset,
   dcdc_req_if.sink   req_chan,
   dcdc_rsp_if.source rsp_chan
);
   dcdc_cmd_type    cmd;
   dcdc_status_type status;
   logic [IdxW-1:0] step;
   logic            req_ready;

   // Controller: sequence load, closure lap, compare and commit
   dcdc_ctrl #(
      .MAX_EQUATIONS (MAX_EQUATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_row),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd),
      .step      (step)
   );

   // Datapath: row ring, Warshall update, coverage check and result register
   dcdc_dpath #(
      .MAX_EQUATIONS (MAX_EQUATIONS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .step         (step),
      .uses_x_row   (req_chan.uses_x_row),
      .uses_y_row   (req_chan.uses_y_row),
      .rsp_ready    (rsp_chan.ready),
      .status       (status),
      .rsp_valid    (rsp_chan.valid),
      .decomposable (rsp_chan.decomposable),
      .overflow     (rsp_chan.overflow)
   );

   assign req_chan.ready = req_ready;

   // Hold off new rows for the closure once a last-row transaction is taken
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_row) |=> !req_chan.ready)
      else $error("request accepted during closure");

   // A result transaction appears only through a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.commit_en))
      else $error("result valid without commit");

   // Never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_en |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("pending result overwritten");

endmodule

// ----- hw/rtl/dcdc_dpath.sv -----
module dcdc_dpath
   import dcdc_pkg::*;
#(
   parameter int MAX_EQUATIONS = MAX_EQUATIONS_DEFAULT,
   localparam int IdxW = (MAX_EQUATIONS > 1) ? $clog2(MAX_EQUATIONS) : 1,
   localparam int CntW = $clog2(MAX_EQUATIONS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  dcdc_cmd_type        cmd,
   input  logic [IdxW-1:0]     step,
   input  logic [ROW_IN_W-1:0] uses_x_row,
   input  logic [ROW_IN_W-1:0] uses_y_row,
   input  logic                rsp_ready,
   output dcdc_status_type     status,
   output logic                rsp_valid,
   output logic                decomposable,
   output logic                overflow
);
   localparam int W = MAX_EQUATIONS;

   logic [W-1:0]          ring_ff [W];
   logic [W-1:0]          ring_in [W];
   logic [W-1:0]          upd     [W];
   logic [W+ROW_IN_W-1:0] row_ext;
   logic [W-1:0]          row_new;
   logic [W-1:0]          mask;
   logic [W-1:0]          full_ff, full_in;
   logic [CntW-1:0]       row_count_ff, row_count_in;
   logic                  overflow_ff, overflow_in;
   logic                  decomp_ff, decomp_in;
   logic                  ovf_out_ff, ovf_out_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  has_room;
   logic                  pivot_en;

   assign row_ext  = {{W{1'b0}}, uses_x_row | uses_y_row};
   assign row_new  = row_ext[W-1:0];
   assign has_room = row_count_ff < CntW'(W);
   assign pivot_en = CntW'(step) < row_count_ff;

   // Warshall step: row at the head of the ring is pivot row 'step'
   always_comb begin
      for (int p = 0; p < W; p++) begin
         upd[p] = ring_ff[p] | ((pivot_en && ring_ff[p][step]) ? ring_ff[0] : '0);
      end
   end

   always_comb begin
      for (int p = 0; p < W; p++) begin
         ring_in[p] = ring_ff[p];
      end
      if (cmd.rotate_en) begin
         for (int p = 0; p < W; p++) begin
            ring_in[p] = upd[(p + 1) % W];
         end
      end else if (cmd.load_en && has_room) begin
         for (int p = 0; p < W; p++) begin
            if (row_count_ff[IdxW-1:0] == IdxW'(p)) begin
               ring_in[p] = row_new;
            end
         end
      end
   end

   // Columns at N or above are ignored; rows at N or above are not part of the set
   always_comb begin
      for (int j = 0; j < W; j++) begin
         mask[j]    = CntW'(j) < row_count_ff;
         full_in[j] = ((ring_ff[j] & mask) == mask) && (CntW'(j) < row_count_ff);
      end
   end

   always_comb begin
      row_count_in = row_count_ff;
      overflow_in  = overflow_ff;
      decomp_in    = decomp_ff;
      ovf_out_in   = ovf_out_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_en) begin
         if (has_room) begin
            row_count_in = row_count_ff + CntW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.commit_en) begin
         decomp_in    = ~(|full_ff);
         ovf_out_in   = overflow_ff;
         rsp_valid_in = 1'b1;
         row_count_in = '0;
         overflow_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < W; p++) begin
         ring_ff[p] <= ring_in[p];
      end
      if (cmd.compare_en) begin
         full_ff <= full_in;
      end
      decomp_ff  <= decomp_in;
      ovf_out_ff <= ovf_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign decomposable    = decomp_ff;
   assign overflow        = ovf_out_ff;

endmodule

// ----- hw/rtl/dcdc_ctrl.sv -----
module dcdc_ctrl
   import dcdc_pkg::*;
#(
   parameter int MAX_EQUATIONS = MAX_EQUATIONS_DEFAULT,
   localparam int IdxW = (MAX_EQUATIONS > 1) ? $clog2(MAX_EQUATIONS) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   input  dcdc_status_type status,
   output logic            req_ready,
   output dcdc_cmd_type    cmd,
   output logic [IdxW-1:0] step
);
   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_CLOSE = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_LOAD: begin
            req_ready   = 1'b1;
            cmd.load_en = req_valid;
            step_in     = '0;
            if (req_valid && req_last) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            // rotate a full lap so the ring ends aligned
            cmd.rotate_en = 1'b1;
            step_in       = step_ff + IdxW'(1);
            if (step_ff == IdxW'(MAX_EQUATIONS - 1)) begin
               step_in  = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.compare_en = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.commit_en = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign step = step_ff;

endmodule
